@@ rtl/ttl_cache_oldest_evict_core_defines.svh @@
// Assertion macros for the TTL cache core.
// Used by the top level; expects signals named clock and reset in scope.
`ifndef TTL_CACHE_OLDEST_EVICT_CORE_DEFINES_SVH
`define TTL_CACHE_OLDEST_EVICT_CORE_DEFINES_SVH

// Same-cycle implication
`define TCE_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define TCE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/tce_pkg.sv @@
// Shared constants and types for the TTL cache core.
// No dependencies; imported by tce_scan, the top level, the checker and the testbench.
package tce_pkg;

   localparam int CAPACITY    = 16;
   localparam int SLOT_BITS   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int ADDR_BITS   = $clog2(CAPACITY + 1);
   localparam int CNT_BITS    = $clog2(CAPACITY + 1);
   localparam int KEY_BITS    = 64;
   localparam int VALUE_BITS  = 32;
   localparam int TIME_BITS   = 32;
   localparam int TTL_BITS    = 31;
   localparam int LIMIT_BITS  = 5;
   localparam int ECOUNT_BITS = 5;
   localparam int FOUND_BITS  = 32;
   localparam int CSR_IDX_BITS = 1;
   localparam int CSR_DATA_BITS = 31;
   localparam int CMP_BITS    = (CNT_BITS > LIMIT_BITS) ? CNT_BITS : LIMIT_BITS;

   localparam logic [LIMIT_BITS-1:0] MAX_RESET = LIMIT_BITS'(16);
   localparam logic [TTL_BITS-1:0]   TTL_RESET = TTL_BITS'(3600);

   typedef enum logic [1:0] {
      ACT_LOOKUP     = 2'd0,
      ACT_STORE      = 2'd1,
      ACT_INVALIDATE = 2'd2,
      ACT_TICK       = 2'd3
   } action_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_MAX_ENTRIES = 1'b0,
      CSR_TTL_TICKS   = 1'b1
   } csr_index_type;

   // One stored entry
   typedef struct packed {
      logic [KEY_BITS-1:0]   key;
      logic [VALUE_BITS-1:0] value;
      logic [TIME_BITS-1:0]  stamp;
   } entry_type;

   localparam int ENTRY_BITS = $bits(entry_type);

   // Slot being examined this cycle
   typedef struct packed {
      logic                 valid;
      logic [SLOT_BITS-1:0] slot;
      logic                 slot_valid;
   } scan_beat_type;

   // Outcome of a full pass over the table
   typedef struct packed {
      logic                  match_found;
      logic                  match_expired;
      logic [SLOT_BITS-1:0]  match_slot;
      logic [VALUE_BITS-1:0] match_value;
      logic                  oldest_found;
      logic [SLOT_BITS-1:0]  oldest_slot;
      logic                  free_found;
      logic [SLOT_BITS-1:0]  free_slot;
   } scan_result_type;

endpackage

@@ rtl/tce_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module tce_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/tce_scan.sv @@
// Scan accumulator: looks at one slot per cycle and keeps the key match,
// the oldest live entry and the lowest free slot. Depends on tce_pkg.
module tce_scan import tce_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  scan_beat_type         beat,
   input  entry_type             rd_entry,
   input  logic [KEY_BITS-1:0]   req_key,
   input  logic [TIME_BITS-1:0]  time_now,
   input  logic [TTL_BITS-1:0]   ttl_ticks,
   output logic                  cur_expired,
   output scan_result_type       result
);

   scan_result_type        res_ff, res_in;
   logic [TIME_BITS-1:0]   oldest_age_ff, oldest_age_in;
   logic [TIME_BITS-1:0]   age;
   logic                   live;
   logic                   key_eq;

   // age wraps modulo 2^32
   assign age         = time_now - rd_entry.stamp;
   assign cur_expired = age > {1'b0, ttl_ticks};
   assign live        = beat.slot_valid && !cur_expired;
   assign key_eq      = rd_entry.key == req_key;

   always_comb begin
      res_in        = res_ff;
      oldest_age_in = oldest_age_ff;
      if (beat.valid) begin
         // keys are unique, the first valid match is the only one
         if (beat.slot_valid && key_eq && !res_ff.match_found) begin
            res_in.match_found   = 1'b1;
            res_in.match_expired = cur_expired;
            res_in.match_slot    = beat.slot;
            res_in.match_value   = rd_entry.value;
         end
         // strictly greater keeps the lowest slot on ties
         if (live && (!res_ff.oldest_found || age > oldest_age_ff)) begin
            res_in.oldest_found = 1'b1;
            res_in.oldest_slot  = beat.slot;
            oldest_age_in       = age;
         end
         // expired slots count as free, a store drops them
         if ((!beat.slot_valid || cur_expired) && !res_ff.free_found) begin
            res_in.free_found = 1'b1;
            res_in.free_slot  = beat.slot;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || start) begin
         res_ff.match_found  <= 1'b0;
         res_ff.oldest_found <= 1'b0;
         res_ff.free_found   <= 1'b0;
      end else begin
         res_ff.match_found  <= res_in.match_found;
         res_ff.oldest_found <= res_in.oldest_found;
         res_ff.free_found   <= res_in.free_found;
      end
      res_ff.match_expired <= res_in.match_expired;
      res_ff.match_slot    <= res_in.match_slot;
      res_ff.match_value   <= res_in.match_value;
      res_ff.oldest_slot   <= res_in.oldest_slot;
      res_ff.free_slot     <= res_in.free_slot;
      oldest_age_ff        <= oldest_age_in;
   end

   assign result = res_ff;

endmodule

@@ rtl/ttl_cache_oldest_evict_core.sv @@
// Top level of the TTL cache: sequencer, valid bits, counters and registers.
// Depends on tce_pkg, tce_ram, tce_scan and ttl_cache_oldest_evict_core_defines.svh.
//
//   channel  direction  handshake           payload
//   req      in         req_valid/req_stall action, fingerprint_key, store_value
//   rsp      out        rsp_valid/rsp_stall hit, found_value, entry_count
//   csr      in         csr_write_en        csr_index, csr_wdata
//
// Lookup and store: the scan reads the entry RAM one slot at a time, the scan accumulator
// takes each read data, ST_FINISH updates the table and ST_DONE loads the result.
// Invalidate, tick and ignored stores go from accept straight to ST_DONE to load the result.
// Reset clears all valid bits at once; no clearing pass is needed.
// One item is in work at a time; a held result only delays its completion.
`include "ttl_cache_oldest_evict_core_defines.svh"

module ttl_cache_oldest_evict_core import tce_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [1:0]               req_action,
   input  logic [KEY_BITS-1:0]      req_fingerprint_key,
   input  logic [VALUE_BITS-1:0]    req_store_value,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_hit,
   output logic [FOUND_BITS-1:0]    rsp_found_value,
   output logic [ECOUNT_BITS-1:0]   rsp_entry_count,
   input  logic                     csr_write_en,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_FINISH = 4'b0100,
      ST_DONE   = 4'b1000
   } state_type;

   state_type              state_ff, state_in;
   logic [CAPACITY-1:0]    valid_ff, valid_in;
   logic [CNT_BITS-1:0]    valid_count_ff, valid_count_in;
   logic [TIME_BITS-1:0]   time_now_ff;
   logic [LIMIT_BITS-1:0]  max_entries_ff;
   logic [TTL_BITS-1:0]    ttl_ticks_ff;

   action_type             op_ff;
   logic [KEY_BITS-1:0]    key_ff;
   logic [VALUE_BITS-1:0]  value_ff;
   logic                   res_hit_ff;
   logic [VALUE_BITS-1:0]  res_value_ff;

   logic [ADDR_BITS-1:0]   rd_addr_ff;
   logic                   beat_valid_ff;
   logic [SLOT_BITS-1:0]   beat_slot_ff;

   logic                   rsp_valid_ff;
   logic                   rsp_hit_ff;
   logic [FOUND_BITS-1:0]  rsp_found_value_ff;
   logic [ECOUNT_BITS-1:0] rsp_entry_count_ff;

   logic                   req_take;
   logic                   rd_en;
   logic                   scan_last;
   logic                   out_free;
   logic                   store_ok;
   action_type             req_op;
   entry_type              rd_entry, wr_entry;
   logic                   wr_en;
   scan_beat_type          beat;
   scan_result_type        res;
   logic                   cur_expired;

   logic [CMP_BITS-1:0]    limit;
   logic [CMP_BITS-1:0]    max_ext;
   logic                   do_evict;
   logic                   keep_match;
   logic                   use_oldest;
   logic [SLOT_BITS-1:0]   target_slot;

   assign req_op    = action_type'(req_action);
   assign req_stall = state_ff != ST_IDLE;
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign store_ok  = (req_fingerprint_key != '0) && (req_store_value != '0);

   // entry RAM
   assign rd_en     = (state_ff == ST_SCAN) && (rd_addr_ff < ADDR_BITS'(CAPACITY));
   assign wr_en     = (state_ff == ST_FINISH) && (op_ff == ACT_STORE);
   assign wr_entry  = '{key: key_ff, value: value_ff, stamp: time_now_ff};

   tce_ram #(
      .WIDTH(ENTRY_BITS),
      .DEPTH(CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (target_slot),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (rd_addr_ff[SLOT_BITS-1:0]),
      .rd_data (rd_entry)
   );

   // scan accumulator
   assign beat = '{valid: beat_valid_ff, slot: beat_slot_ff,
                   slot_valid: valid_ff[beat_slot_ff]};

   tce_scan u_scan (
      .clock       (clock),
      .reset       (reset),
      .start       (req_take),
      .beat        (beat),
      .rd_entry    (rd_entry),
      .req_key     (key_ff),
      .time_now    (time_now_ff),
      .ttl_ticks   (ttl_ticks_ff),
      .cur_expired (cur_expired),
      .result      (res)
   );

   assign scan_last = beat_valid_ff && (beat_slot_ff == SLOT_BITS'(CAPACITY - 1));

   // limit: zero counts as one, above capacity saturates
   assign max_ext = CMP_BITS'(max_entries_ff);
   always_comb begin
      if (max_entries_ff == '0) begin
         limit = CMP_BITS'(1);
      end else if (max_ext > CMP_BITS'(CAPACITY)) begin
         limit = CMP_BITS'(CAPACITY);
      end else begin
         limit = max_ext;
      end
   end

   // store placement after expiry drops and eviction
   assign do_evict   = (CMP_BITS'(valid_count_ff) >= limit) && res.oldest_found;
   assign keep_match = res.match_found && !res.match_expired
                       && !(do_evict && (res.oldest_slot == res.match_slot));
   assign use_oldest = do_evict && (!res.free_found || (res.oldest_slot < res.free_slot));
   always_comb begin
      if (keep_match) begin
         target_slot = res.match_slot;
      end else if (use_oldest) begin
         target_slot = res.oldest_slot;
      end else begin
         target_slot = res.free_slot;
      end
   end

   // valid bits and count
   always_comb begin
      valid_in       = valid_ff;
      valid_count_in = valid_count_ff;
      if (req_take && (req_op == ACT_INVALIDATE)) begin
         valid_in       = '0;
         valid_count_in = '0;
      end else if ((state_ff == ST_SCAN) && (op_ff == ACT_STORE) && beat_valid_ff
                   && valid_ff[beat_slot_ff] && cur_expired) begin
         valid_in[beat_slot_ff] = 1'b0;
         valid_count_in         = valid_count_ff - CNT_BITS'(1);
      end else if (state_ff == ST_FINISH) begin
         if (op_ff == ACT_STORE) begin
            if (do_evict) begin
               valid_in[res.oldest_slot] = 1'b0;
            end
            valid_in[target_slot] = 1'b1;
            valid_count_in = valid_count_ff - CNT_BITS'(do_evict) + CNT_BITS'(!keep_match);
         end else if (res.match_found && res.match_expired) begin
            valid_in[res.match_slot] = 1'b0;
            valid_count_in           = valid_count_ff - CNT_BITS'(1);
         end
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if ((req_op == ACT_LOOKUP) || ((req_op == ACT_STORE) && store_ok)) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_SCAN: begin
            if (scan_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         valid_ff       <= '0;
         valid_count_ff <= '0;
         time_now_ff    <= '0;
         max_entries_ff <= MAX_RESET;
         ttl_ticks_ff   <= TTL_RESET;
         beat_valid_ff  <= 1'b0;
         rd_addr_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         valid_ff       <= valid_in;
         valid_count_ff <= valid_count_in;
         if (req_take && (req_op == ACT_TICK)) begin
            time_now_ff <= time_now_ff + TIME_BITS'(1);
         end
         if (csr_write_en) begin
            case (csr_index_type'(csr_index))
               CSR_MAX_ENTRIES: max_entries_ff <= csr_wdata[LIMIT_BITS-1:0];
               CSR_TTL_TICKS:   ttl_ticks_ff   <= csr_wdata[TTL_BITS-1:0];
               default: begin
               end
            endcase
         end
         if (req_take) begin
            rd_addr_ff    <= '0;
            beat_valid_ff <= 1'b0;
         end else begin
            beat_valid_ff <= rd_en;
            if (rd_en) begin
               rd_addr_ff <= rd_addr_ff + ADDR_BITS'(1);
            end
         end
         if ((state_ff == ST_DONE) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         op_ff        <= req_op;
         key_ff       <= req_fingerprint_key;
         value_ff     <= req_store_value;
         res_hit_ff   <= 1'b0;
         res_value_ff <= '0;
      end else if ((state_ff == ST_FINISH) && (op_ff == ACT_LOOKUP)
                   && res.match_found && !res.match_expired) begin
         res_hit_ff   <= 1'b1;
         res_value_ff <= res.match_value;
      end
      beat_slot_ff <= rd_addr_ff[SLOT_BITS-1:0];
      if ((state_ff == ST_DONE) && out_free) begin
         rsp_hit_ff         <= res_hit_ff;
         rsp_found_value_ff <= FOUND_BITS'(res_value_ff);
         rsp_entry_count_ff <= ECOUNT_BITS'(valid_count_ff);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_found_value = rsp_found_value_ff;
   assign rsp_entry_count = rsp_entry_count_ff;

   // checks
   `TCE_ASSERT_NOW(a_count_matches_bits, 1'b1,
      valid_count_ff == CNT_BITS'($countones(valid_ff)), "entry count out of step")
   `TCE_ASSERT_NEXT(a_busy_after_accept, req_take,
      state_ff != ST_IDLE, "accepted item did not start")
   `TCE_ASSERT_NEXT(a_store_target_valid, wr_en,
      valid_ff[$past(target_slot)], "stored slot not marked valid")
   `TCE_ASSERT_NOW(a_write_not_during_read, wr_en, !rd_en, "RAM read and write overlap")

endmodule

@@ test/ttl_cache_checker.sv @@
// Checker for the TTL cache core: watches the request, response and register ports,
// predicts every response and compares it with the one the core returns.
// Depends on tce_pkg for widths, action codes and register indexes.
module ttl_cache_checker import tce_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  logic [1:0]               req_action,
   input  logic [KEY_BITS-1:0]      req_fingerprint_key,
   input  logic [VALUE_BITS-1:0]    req_store_value,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  logic                     rsp_hit,
   input  logic [FOUND_BITS-1:0]    rsp_found_value,
   input  logic [ECOUNT_BITS-1:0]   rsp_entry_count,
   input  logic                     csr_write_en,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata,
   output int                       mismatch_count,
   output int                       outstanding,
   output int                       results_seen,
   output int                       hits_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic                   hit;
      logic [FOUND_BITS-1:0]  found_value;
      logic [ECOUNT_BITS-1:0] entry_count;
   } answer_type;

   // Responses still owed by the core, oldest first
   answer_type answer_q[$];

   // Predicted table contents
   logic                  slot_live  [CAPACITY];
   logic [KEY_BITS-1:0]   slot_key   [CAPACITY];
   logic [VALUE_BITS-1:0] slot_value [CAPACITY];
   logic [TIME_BITS-1:0]  slot_stamp [CAPACITY];
   logic [TIME_BITS-1:0]  clock_ticks;
   int                    live_count;
   logic [LIMIT_BITS-1:0] entry_limit_reg;
   logic [TTL_BITS-1:0]   lifetime_reg;

   int fault_total;
   int result_total;
   int hit_total;

   function automatic logic [TIME_BITS-1:0] slot_age(int s);
      return clock_ticks - slot_stamp[s];
   endfunction

   function automatic bit slot_stale(int s);
      return slot_age(s) > {1'b0, lifetime_reg};
   endfunction

   function automatic void drop(int s);
      if (slot_live[s]) begin
         slot_live[s] = 1'b0;
         live_count--;
      end
   endfunction

   function automatic int find_slot(logic [KEY_BITS-1:0] key);
      for (int i = 0; i < CAPACITY; i++)
         if (slot_live[i] && slot_key[i] == key)
            return i;
      return -1;
   endfunction

   // Apply one request to the predicted table and return the response it owes
   function automatic answer_type apply_item(action_type act, logic [KEY_BITS-1:0] key,
                                             logic [VALUE_BITS-1:0] val);
      answer_type ans;
      int s;
      int limit;
      int pick;
      logic [TIME_BITS-1:0] oldest_age;
      ans = '0;
      case (act)
         ACT_LOOKUP: begin
            s = find_slot(key);
            if (s >= 0) begin
               // an entry past its lifetime is removed and the lookup misses
               if (slot_stale(s)) begin
                  drop(s);
               end else begin
                  ans.hit = 1'b1;
                  ans.found_value = slot_value[s];
               end
            end
         end
         ACT_STORE: begin
            // empty key or null value: store ignored
            if (key != '0 && val != '0) begin
               for (int i = 0; i < CAPACITY; i++)
                  if (slot_live[i] && slot_stale(i))
                     drop(i);
               limit = (entry_limit_reg == '0) ? 1 : int'(entry_limit_reg);
               if (limit > CAPACITY)
                  limit = CAPACITY;
               // full: evict greatest age, lowest slot on ties (even the same key)
               if (live_count >= limit) begin
                  pick = -1;
                  oldest_age = '0;
                  for (int i = 0; i < CAPACITY; i++) begin
                     if (slot_live[i] && (pick < 0 || slot_age(i) > oldest_age)) begin
                        pick = i;
                        oldest_age = slot_age(i);
                     end
                  end
                  if (pick >= 0)
                     drop(pick);
               end
               s = find_slot(key);
               for (int i = 0; i < CAPACITY; i++)
                  if (s < 0 && !slot_live[i])
                     s = i;
               if (s >= 0) begin
                  if (!slot_live[s]) begin
                     slot_live[s] = 1'b1;
                     live_count++;
                  end
                  slot_key[s] = key;
                  slot_value[s] = val;
                  slot_stamp[s] = clock_ticks;
               end
            end
         end
         ACT_INVALIDATE: begin
            for (int i = 0; i < CAPACITY; i++)
               slot_live[i] = 1'b0;
            live_count = 0;
         end
         ACT_TICK: begin
            clock_ticks = clock_ticks + TIME_BITS'(1);
         end
         default: begin
         end
      endcase
      ans.entry_count = ECOUNT_BITS'(live_count);
      return ans;
   endfunction

   // Compare responses, predict requests, track register writes
   always @(posedge clock) begin
      answer_type got;
      answer_type want;
      if (reset) begin
         for (int i = 0; i < CAPACITY; i++) begin
            slot_live[i] = 1'b0;
            slot_key[i] = '0;
            slot_value[i] = '0;
            slot_stamp[i] = '0;
         end
         clock_ticks = '0;
         live_count = 0;
         entry_limit_reg = MAX_RESET;
         lifetime_reg = TTL_RESET;
         answer_q.delete();
         fault_total = 0;
         result_total = 0;
         hit_total = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_hit, rsp_found_value, rsp_entry_count};
            result_total++;
            if (answer_q.size() == 0) begin
               fault_total++;
               if (fault_total <= 10)
                  $display("%0t: response with none pending: hit %0b value %h count %0d",
                           $realtime, got.hit, got.found_value, got.entry_count);
            end else begin
               want = answer_q.pop_front();
               if (want.hit)
                  hit_total++;
               if (got.hit !== want.hit || got.found_value !== want.found_value ||
                   got.entry_count !== want.entry_count) begin
                  fault_total++;
                  if (fault_total <= 10)
                     $display("%0t: mismatch: expected %0b/%h/%0d, got %0b/%h/%0d",
                              $realtime, want.hit, want.found_value, want.entry_count,
                              got.hit, got.found_value, got.entry_count);
               end
            end
         end
         if (req_valid && !req_stall)
            answer_q.push_back(apply_item(action_type'(req_action), req_fingerprint_key,
                                          req_store_value));
         if (csr_write_en) begin
            case (csr_index_type'(csr_index))
               CSR_MAX_ENTRIES: entry_limit_reg = csr_wdata[LIMIT_BITS-1:0];
               CSR_TTL_TICKS:   lifetime_reg = csr_wdata[TTL_BITS-1:0];
               default: begin
               end
            endcase
         end
      end
      outstanding <= answer_q.size();
      mismatch_count <= fault_total;
      results_seen <= result_total;
      hits_seen <= hit_total;
   end

endmodule

@@ test/tb.sv @@
// Top of the TTL cache test: clock, reset, request and register stimulus, response stalls.
// Depends on tce_pkg, ttl_cache_oldest_evict_core and ttl_cache_checker.
module tb;
   import tce_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASES = 8;
   localparam int PHASE_ITEMS = 250;
   localparam int POOL_DEPTH = 24;
   localparam int PHASE_LIMIT [PHASES] = '{16, 1, 31, 4, 0, 8, 2, 16};
   localparam int PHASE_TTL   [PHASES] = '{8, 0, 30, 2147483647, 4, 15, 60, 3600};
   localparam int PHASE_POOL  [PHASES] = '{20, 6, 24, 12, 6, 16, 24, 20};

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [1:0]               req_action = ACT_LOOKUP;
   logic [KEY_BITS-1:0]      req_fingerprint_key = '0;
   logic [VALUE_BITS-1:0]    req_store_value = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic                     rsp_hit;
   logic [FOUND_BITS-1:0]    rsp_found_value;
   logic [ECOUNT_BITS-1:0]   rsp_entry_count;
   logic                     csr_write_en = 1'b0;
   logic [CSR_IDX_BITS-1:0]  csr_index = CSR_MAX_ENTRIES;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   int mismatch_count;
   int outstanding;
   int results_seen;
   int hits_seen;

   bit calm;
   int rsp_hold;
   int idle_cycles;
   int items_sent;
   int settings_used;
   int pool_size;
   logic [KEY_BITS-1:0] key_pool [POOL_DEPTH];

   ttl_cache_oldest_evict_core dut (.*);

   ttl_cache_checker cache_watch (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Response side: random stall before each item, none in calm stretches
   always @(posedge clock) begin
      if (reset) begin
         rsp_hold = 0;
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall)
            rsp_hold = calm ? 0 : $urandom_range(0, 6);
         rsp_stall <= (rsp_hold != 0);
         if (rsp_hold != 0)
            rsp_hold--;
      end
   end

   // Watchdog: too long without any item moving on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no progress for %0d cycles", idle_cycles);
         $display("RESULT: ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Present one request after a random gap and hold it until taken
   task automatic send_item(action_type act, logic [KEY_BITS-1:0] key,
                            logic [VALUE_BITS-1:0] val);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_fingerprint_key <= key;
      req_store_value <= val;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   // Stop sending and wait until every owed response has come back
   task automatic drain_wait();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0)
         @(posedge clock);
   endtask

   // Write both registers; junk in the unused upper bits of the limit write
   task automatic configure(logic [LIMIT_BITS-1:0] lim, logic [TTL_BITS-1:0] ttl);
      drain_wait();
      csr_write_en <= 1'b1;
      csr_index <= CSR_MAX_ENTRIES;
      csr_wdata <= {(CSR_DATA_BITS-LIMIT_BITS)'($urandom), lim};
      @(posedge clock);
      csr_index <= CSR_TTL_TICKS;
      csr_wdata <= ttl;
      @(posedge clock);
      csr_write_en <= 1'b0;
      settings_used++;
   endtask

   function automatic logic [KEY_BITS-1:0] pick_key();
      if ($urandom_range(0, 19) == 0)
         return {$urandom, $urandom};
      return key_pool[$urandom_range(0, pool_size - 1)];
   endfunction

   function automatic logic [VALUE_BITS-1:0] pick_value();
      if ($urandom_range(0, 19) == 0)
         return '0;
      return $urandom;
   endfunction

   function automatic action_type pick_action();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40)
         return ACT_LOOKUP;
      if (r < 75)
         return ACT_STORE;
      if (r < 97)
         return ACT_TICK;
      return ACT_INVALIDATE;
   endfunction

   initial begin
      logic [LIMIT_BITS-1:0] lim;
      key_pool[0] = '0;
      for (int i = 1; i < POOL_DEPTH; i++)
         key_pool[i] = {$urandom, $urandom};
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: empty table, widest key and value, ignored stores, overwrite
      send_item(ACT_LOOKUP, '0, '0);
      send_item(ACT_STORE, '1, '1);
      send_item(ACT_LOOKUP, '1, '0);
      send_item(ACT_STORE, '0, 32'd5);
      send_item(ACT_STORE, 64'd5, '0);
      send_item(ACT_LOOKUP, '0, '1);
      send_item(ACT_STORE, '1, 32'h0000_1234);
      send_item(ACT_LOOKUP, '1, '0);
      send_item(ACT_TICK, '0, '0);
      send_item(ACT_INVALIDATE, '1, '1);
      send_item(ACT_LOOKUP, '1, '0);

      // Limit of one, zero lifetime: eviction of the same key, expiry after one tick
      configure(LIMIT_BITS'(1), '0);
      send_item(ACT_STORE, 64'd1, 32'd1);
      send_item(ACT_STORE, 64'd2, 32'd2);
      send_item(ACT_STORE, 64'd2, 32'd3);
      send_item(ACT_LOOKUP, 64'd2, '0);
      send_item(ACT_TICK, '0, '0);
      send_item(ACT_LOOKUP, 64'd2, '0);

      // Zero limit acts as one; longest lifetime
      configure('0, '1);
      send_item(ACT_STORE, 64'd1, 32'd1);
      send_item(ACT_STORE, 64'd2, 32'd2);
      send_item(ACT_LOOKUP, 64'd1, '0);

      // Equal ages: lowest slot goes first; then expiry by age
      configure(LIMIT_BITS'(3), TTL_BITS'(2));
      send_item(ACT_INVALIDATE, '0, '0);
      send_item(ACT_STORE, 64'd3, 32'd3);
      send_item(ACT_STORE, 64'd4, 32'd4);
      send_item(ACT_STORE, 64'd5, 32'd5);
      send_item(ACT_STORE, 64'd6, 32'd6);
      send_item(ACT_LOOKUP, 64'd3, '0);
      repeat (3) send_item(ACT_TICK, '0, '0);
      send_item(ACT_LOOKUP, 64'd4, '0);

      // Random phases, each with its own register settings and key pool
      for (int p = 0; p < PHASES; p++) begin
         lim = LIMIT_BITS'(PHASE_LIMIT[p]);
         if (p == 6)
            lim = LIMIT_BITS'($urandom_range(0, 31));
         configure(lim, TTL_BITS'(PHASE_TTL[p]));
         pool_size = PHASE_POOL[p];
         calm = ($urandom_range(0, 3) == 0);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 50 == 49 && !calm)
               calm = ($urandom_range(0, 2) == 0);
            else if (n % 50 == 49)
               calm = 1'b0;
            if ($urandom_range(0, 149) == 0)
               drain_wait();
            send_item(pick_action(), pick_key(), pick_value());
         end
      end
      calm = 1'b0;

      drain_wait();
      repeat (40) @(posedge clock);
      $display("Sent %0d requests under %0d register settings; %0d responses checked, %0d hits.",
               items_sent, settings_used, results_seen, hits_seen);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d mismatches, %0d responses missing", mismatch_count, outstanding);
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
